>>> src/cdp_pkg.sv
// Shared types and constants for the codebook dot-product block.
// Holds table geometry, value and accumulator widths, item kind codes and the
// table write-port bundle. No dependencies.
package cdp_pkg;

	// Table and datapath geometry.
	localparam int TABLE_ENTRIES = 256;
	localparam int VALUE_BITS    = 16;
	localparam int ACC_BITS      = 48;
	localparam int INDEX_BITS    = 8;
	localparam int ADDR_BITS     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int PROD_BITS     = 2 * VALUE_BITS;
	localparam int SUM_BITS      = ((PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS) + 1;

	// One more bit than an index so the entry count itself can be compared against.
	localparam logic [INDEX_BITS:0] TABLE_LIMIT = (INDEX_BITS + 1)'(TABLE_ENTRIES);

	typedef logic [INDEX_BITS-1:0]       index_t;
	typedef logic [ADDR_BITS-1:0]        addr_t;
	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	// Saturation limits of the accumulator.
	localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	// Item kind codes.
	localparam logic KIND_PAIR  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Write port of the value table.
	typedef struct packed {
		logic   en;
		index_t addr;
		value_t data;
	} table_wr_t;

endpackage

>>> src/codebook_dot_product.sv
// Top level of the codebook dot-product block.
// Depends on cdp_pkg and instantiates cdp_value_table.
//
// Usage:
// Items enter on the item channel (item_valid / item_stall). An item of kind
// write stores entry_value at entry_address in the value table and gives no
// result. An item of kind pair looks up index_a and index_b, multiplies the
// two values and adds the product to a saturating accumulator. A pair item
// with last set also places the sum and the clip flag on the result channel
// (result_valid / result_stall) and clears the accumulator.
// Pipeline: the table read is registered at the accepting edge, then come
// the product and the accumulate-and-output registers. Throughput is one item
// per cycle while no result waits under result_stall.
// A table write is visible to any pair item accepted after it.
// Reset clears the pipeline, the accumulator and the clip flag; the table
// contents are undefined until written.
// While a result waits under result_stall, the whole pipeline holds and
// item_stall is raised; it drops in the cycle the result is taken.
module codebook_dot_product (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic            kind,
	input  cdp_pkg::index_t entry_address,
	input  cdp_pkg::value_t entry_value,
	input  cdp_pkg::index_t index_a,
	input  cdp_pkg::index_t index_b,
	input  logic            last,
	output logic            result_valid,
	input  logic            result_stall,
	output cdp_pkg::acc_t   dot_sum,
	output logic            saturated
);
	import cdp_pkg::*;

	logic      advance;
	logic      accept;
	table_wr_t table_wr;
	value_t    value_a_s1;
	value_t    value_b_s1;
	logic      valid_s1;
	logic      last_s1;
	prod_t     product_s2;
	logic      valid_s2;
	logic      last_s2;
	acc_t      acc_q;
	logic      clip_q;
	logic      result_valid_q;
	acc_t      dot_sum_q;
	logic      saturated_q;
	sum_t      sum_wide;
	acc_t      sum_sat;
	logic      clip_now;

	// The pipeline moves whenever the output register is free or being taken.
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = !advance;
	assign accept     = item_valid && advance;

	// Table writes come straight from accepted write items.
	assign table_wr.en   = accept && (kind == KIND_WRITE);
	assign table_wr.addr = entry_address;
	assign table_wr.data = entry_value;

	cdp_value_table u_table (
		.clk        (clk),
		.wr         (table_wr),
		.rd_en      (advance),
		.rd_index_a (index_a),
		.rd_index_b (index_b),
		.rd_value_a (value_a_s1),
		.rd_value_b (value_b_s1)
	);

	// Stage 1 control travels alongside the registered table read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && (kind == KIND_PAIR);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_s1 <= last;
		end
	end

	// Stage 2: exact product of the two table values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			product_s2 <= PROD_BITS'(value_a_s1) * PROD_BITS'(value_b_s1);
			last_s2    <= last_s1;
		end
	end

	// Exact sum, then clamp to the accumulator range.
	always_comb begin
		sum_wide = SUM_BITS'(acc_q) + SUM_BITS'(product_s2);
		clip_now = 1'b0;
		sum_sat  = ACC_BITS'(sum_wide);
		if (sum_wide > SUM_BITS'(ACC_MAX)) begin
			sum_sat  = ACC_MAX;
			clip_now = 1'b1;
		end else if (sum_wide < SUM_BITS'(ACC_MIN)) begin
			sum_sat  = ACC_MIN;
			clip_now = 1'b1;
		end
	end

	// Accumulator and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			clip_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s2 && last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= sum_sat;
					clip_q <= clip_q || clip_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dot_sum_q   <= sum_sat;
			saturated_q <= clip_q || clip_now;
		end
	end

	assign result_valid = result_valid_q;
	assign dot_sum      = dot_sum_q;
	assign saturated    = saturated_q;

	// A last pair reaching the accumulator produces a result next cycle.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s2 && last_s2) |=> result_valid)
		else $error("last pair did not produce a result");

	// The accumulator and clip flag are cleared after a vector ends.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s2 && last_s2) |=> (acc_q == '0 && !clip_q))
		else $error("accumulator not cleared after last pair");

	// A table write never enters the multiply path.
	a_write_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_WRITE) |=> !valid_s1)
		else $error("table write entered the pair pipeline");

	// Without a pair in the accumulate stage the accumulator holds.
	a_acc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s2) |=> $stable(acc_q))
		else $error("accumulator changed without a pair");

endmodule

>>> src/cdp_value_table.sv
// Codebook value table: one write port and two registered read ports.
// Depends on cdp_pkg for the geometry and the write-port bundle.
// Indices at or beyond the table size read as zero; writes there are dropped.
module cdp_value_table (
	input  logic              clk,
	input  cdp_pkg::table_wr_t wr,
	input  logic              rd_en,
	input  cdp_pkg::index_t   rd_index_a,
	input  cdp_pkg::index_t   rd_index_b,
	output cdp_pkg::value_t   rd_value_a,
	output cdp_pkg::value_t   rd_value_b
);
	import cdp_pkg::*;

	value_t mem [TABLE_ENTRIES];
	value_t data_a_q;
	value_t data_b_q;
	logic   in_range_a_q;
	logic   in_range_b_q;
	logic   wr_in_range;

	assign wr_in_range = {1'b0, wr.addr} < TABLE_LIMIT;

	// Write and read the storage; read data is registered.
	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			mem[wr.addr[ADDR_BITS-1:0]] <= wr.data;
		end
		if (rd_en) begin
			data_a_q     <= mem[rd_index_a[ADDR_BITS-1:0]];
			data_b_q     <= mem[rd_index_b[ADDR_BITS-1:0]];
			in_range_a_q <= {1'b0, rd_index_a} < TABLE_LIMIT;
			in_range_b_q <= {1'b0, rd_index_b} < TABLE_LIMIT;
		end
	end

	// Out-of-range indices read as zero.
	assign rd_value_a = in_range_a_q ? data_a_q : '0;
	assign rd_value_b = in_range_b_q ? data_b_q : '0;

endmodule
